// ===== hdl/hsvrgb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HSV to RGB332 pipeline.
`timescale 1ns / 1ps

package hsvrgb_pkg;

   localparam logic [15:0] HueSector     = 16'd3840;   // 60 degrees, 6 fraction bits
   localparam logic [15:0] HueLimit      = 16'd23040;  // 360 degrees
   localparam logic [11:0] HueSectorRamp = 12'd3840;
   localparam logic [8:0]  FracOne       = 9'd256;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED,
      SECTOR_NONE
   } sector_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [8:0]  saturation;
      logic [8:0]  brightness;
   } pixel_type;

   typedef struct packed {
      sector_type  sector;
      logic [15:0] hue;
      logic [8:0]  saturation;
      logic [8:0]  brightness;
   } decode_type;

   typedef struct packed {
      sector_type  sector;
      logic [11:0] ramp;
      logic [16:0] chroma_prod;
      logic [8:0]  brightness;
   } ramp_type;

   // Numerators over 65536*3840 for the three possible channel values.
   typedef struct packed {
      sector_type  sector;
      logic [27:0] chroma_num;
      logic [27:0] second_num;
      logic [27:0] offset_num;
   } term_type;

   typedef struct packed {
      logic [2:0] red_level;
      logic [2:0] green_level;
      logic [1:0] blue_level;
      logic [7:0] packed_color;
   } color_type;

   function automatic logic [8:0] clamp_unit(input logic [8:0] x);
      return (x > FracOne) ? FracOne : x;
   endfunction

   function automatic sector_type hue_sector(input logic [15:0] h);
      sector_type s;
      if (h >= HueLimit)                 s = SECTOR_NONE;
      else if (h >= HueSector * 16'd5)   s = SECTOR_MAGENTA_RED;
      else if (h >= HueSector * 16'd4)   s = SECTOR_BLUE_MAGENTA;
      else if (h >= HueSector * 16'd3)   s = SECTOR_CYAN_BLUE;
      else if (h >= HueSector * 16'd2)   s = SECTOR_GREEN_CYAN;
      else if (h >= HueSector)           s = SECTOR_YELLOW_GREEN;
      else                               s = SECTOR_RED_YELLOW;
      return s;
   endfunction

   function automatic logic [15:0] sector_base(input sector_type s);
      logic [15:0] b;
      unique case (s)
         SECTOR_RED_YELLOW:   b = 16'd0;
         SECTOR_YELLOW_GREEN: b = HueSector;
         SECTOR_GREEN_CYAN:   b = HueSector * 16'd2;
         SECTOR_CYAN_BLUE:    b = HueSector * 16'd3;
         SECTOR_BLUE_MAGENTA: b = HueSector * 16'd4;
         SECTOR_MAGENTA_RED:  b = HueSector * 16'd5;
         default:             b = 16'd0;
      endcase
      return b;
   endfunction

   // floor(y/15) for y up to 119, by reciprocal 137/2048
   function automatic logic [2:0] div15(input logic [6:0] y);
      logic [14:0] p;
      p = {8'd0, y} * 15'd137;
      return p[13:11];
   endfunction

   // floor(n*7 / (2^24*15))
   function automatic logic [2:0] scale_seven(input logic [27:0] n);
      logic [30:0] x;
      x = {3'd0, n} * 31'd7;
      return div15(x[30:24]);
   endfunction

   // floor(n*3 / (2^24*15))
   function automatic logic [1:0] scale_three(input logic [27:0] n);
      logic [29:0] x;
      logic [2:0]  q;
      x = {2'd0, n} * 30'd3;
      q = div15({1'b0, x[29:24]});
      return q[1:0];
   endfunction

endpackage

// ===== hdl/hsvrgb_if.sv =====
// Valid/ready channel interfaces for HSV pixels in and RGB332 colours out.
`timescale 1ns / 1ps

interface hsvrgb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] hue;
   logic [8:0]  saturation;
   logic [8:0]  brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsvrgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] red_level;
   logic [2:0] green_level;
   logic [1:0] blue_level;
   logic [7:0] packed_color;

   modport source (output valid, output red_level, output green_level, output blue_level,
                   output packed_color, input ready);
   modport sink   (input valid, input red_level, input green_level, input blue_level,
                   input packed_color, output ready);
endinterface

// ===== hdl/hsvrgb_front.sv =====
// Front stages: clamp and sector decode, then hue ramp and chroma product v*s.
`timescale 1ns / 1ps

module hsvrgb_front
   import hsvrgb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_pixel,
   output logic      out_valid,
   input  logic      out_ready,
   output ramp_type  out_data
);

   logic       dec_valid_ff;
   decode_type dec_data_ff;
   decode_type dec_data_in;
   logic       dec_adv;

   logic       rmp_valid_ff;
   ramp_type   rmp_data_ff;
   ramp_type   rmp_data_in;
   logic       rmp_adv;

   logic [15:0] pos_wide;
   logic [11:0] pos;
   logic [17:0] prod_wide;

   assign rmp_adv  = !rmp_valid_ff || out_ready;
   assign dec_adv  = !dec_valid_ff || rmp_adv;
   assign in_ready = dec_adv;

   always_comb begin
      dec_data_in.sector     = hue_sector(in_pixel.hue);
      dec_data_in.hue        = in_pixel.hue;
      dec_data_in.saturation = clamp_unit(in_pixel.saturation);
      dec_data_in.brightness = clamp_unit(in_pixel.brightness);
   end

   always_comb begin
      pos_wide  = dec_data_ff.hue - sector_base(dec_data_ff.sector);
      pos       = pos_wide[11:0];
      prod_wide = {9'd0, dec_data_ff.brightness} * {9'd0, dec_data_ff.saturation};
      rmp_data_in.sector      = dec_data_ff.sector;
      // falling ramp in odd sectors
      rmp_data_in.ramp        = dec_data_ff.sector[0] ? (HueSectorRamp - pos) : pos;
      rmp_data_in.chroma_prod = prod_wide[16:0];
      rmp_data_in.brightness  = dec_data_ff.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
         rmp_valid_ff <= 1'b0;
      end else begin
         if (dec_adv) dec_valid_ff <= in_valid;
         if (rmp_adv) rmp_valid_ff <= dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_adv) dec_data_ff <= dec_data_in;
      if (rmp_adv) rmp_data_ff <= rmp_data_in;
   end

   assign out_valid = rmp_valid_ff;
   assign out_data  = rmp_data_ff;

endmodule

// ===== hdl/hsvrgb_mid.sv =====
// Middle stages: secondary product and offset terms, then the mixed ramp numerator.
`timescale 1ns / 1ps

module hsvrgb_mid
   import hsvrgb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  ramp_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output term_type out_data
);

   logic     prd_valid_ff;
   term_type prd_data_ff;
   term_type prd_data_in;
   logic     prd_adv;

   logic     mix_valid_ff;
   term_type mix_data_ff;
   term_type mix_data_in;
   logic     mix_adv;

   logic [28:0] second_wide;
   logic [16:0] offset_frac;
   logic [28:0] offset_wide;
   logic [28:0] chroma_wide;
   logic [28:0] mixed_wide;

   assign mix_adv  = !mix_valid_ff || out_ready;
   assign prd_adv  = !prd_valid_ff || mix_adv;
   assign in_ready = prd_adv;

   always_comb begin
      second_wide = {12'd0, in_data.chroma_prod} * {17'd0, in_data.ramp};
      offset_frac = {in_data.brightness, 8'd0} - in_data.chroma_prod;
      // times 3840 as 4096 - 256
      offset_wide = {offset_frac, 12'd0} - {4'd0, offset_frac, 8'd0};
      chroma_wide = {in_data.brightness, 20'd0} - {4'd0, in_data.brightness, 16'd0};
      prd_data_in.sector     = in_data.sector;
      prd_data_in.chroma_num = chroma_wide[27:0];
      prd_data_in.second_num = second_wide[27:0];
      prd_data_in.offset_num = offset_wide[27:0];
   end

   always_comb begin
      mixed_wide = {1'b0, prd_data_ff.second_num} + {1'b0, prd_data_ff.offset_num};
      mix_data_in            = prd_data_ff;
      mix_data_in.second_num = mixed_wide[27:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_valid_ff <= 1'b0;
         mix_valid_ff <= 1'b0;
      end else begin
         if (prd_adv) prd_valid_ff <= in_valid;
         if (mix_adv) mix_valid_ff <= prd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prd_adv) prd_data_ff <= prd_data_in;
      if (mix_adv) mix_data_ff <= mix_data_in;
   end

   assign out_valid = mix_valid_ff;
   assign out_data  = mix_data_ff;

endmodule

// ===== hdl/hsvrgb_back.sv =====
// Back stage: route terms to channels by sector, scale to levels, hold the result beat.
`timescale 1ns / 1ps

module hsvrgb_back
   import hsvrgb_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  term_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output color_type out_color
);

   logic      col_valid_ff;
   color_type col_data_ff;
   color_type col_data_in;
   logic      col_adv;

   logic [27:0] red_num;
   logic [27:0] green_num;
   logic [27:0] blue_num;

   assign col_adv  = !col_valid_ff || out_ready;
   assign in_ready = col_adv;

   always_comb begin
      red_num   = in_data.offset_num;
      green_num = in_data.offset_num;
      blue_num  = in_data.offset_num;
      unique case (in_data.sector)
         SECTOR_RED_YELLOW: begin
            red_num   = in_data.chroma_num;
            green_num = in_data.second_num;
         end
         SECTOR_YELLOW_GREEN: begin
            red_num   = in_data.second_num;
            green_num = in_data.chroma_num;
         end
         SECTOR_GREEN_CYAN: begin
            green_num = in_data.chroma_num;
            blue_num  = in_data.second_num;
         end
         SECTOR_CYAN_BLUE: begin
            green_num = in_data.second_num;
            blue_num  = in_data.chroma_num;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_num   = in_data.second_num;
            blue_num  = in_data.chroma_num;
         end
         SECTOR_MAGENTA_RED: begin
            red_num   = in_data.chroma_num;
            blue_num  = in_data.second_num;
         end
         default: begin
            // hue out of range: offset only
            red_num   = in_data.offset_num;
         end
      endcase
   end

   always_comb begin
      col_data_in.red_level    = scale_seven(red_num);
      col_data_in.green_level  = scale_seven(green_num);
      col_data_in.blue_level   = scale_three(blue_num);
      col_data_in.packed_color = {col_data_in.red_level, col_data_in.green_level,
                                  col_data_in.blue_level};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff <= 1'b0;
      end else if (col_adv) begin
         col_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (col_adv) col_data_ff <= col_data_in;
   end

   assign out_valid = col_valid_ff;
   assign out_color = col_data_ff;

endmodule

// ===== hdl/hsv_to_rgb332_unit.sv =====
// Top level: HSV pixel to 3-3-2 RGB colour converter, five-stage pipeline.
//
//   channel    dir   beat contents
//   req_chan   in    hue[15:0], saturation[8:0], brightness[8:0]
//   rsp_chan   out   red_level[2:0], green_level[2:0], blue_level[1:0], packed_color[7:0]
//
// One pixel per clock while rsp_chan takes every beat; a result shows on rsp_chan once
// its pixel has passed the dec, rmp, prd, mix and col registers.
// The two multiplier stages (v*s, then v*s*ramp) and the constant scaling at the
// end each have their own register.
// Synchronous reset empties every stage; req_chan.ready is low during reset.
// A stalled result holds in the output register; bubbles further up still fill.
`timescale 1ns / 1ps

module hsv_to_rgb332_unit
   import hsvrgb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   hsvrgb_req_if.sink          req_chan,
   hsvrgb_rsp_if.source        rsp_chan
);

   pixel_type pixel;
   logic      front_ready;
   logic      front_valid;
   ramp_type  front_data;
   logic      mid_ready;
   logic      mid_valid;
   term_type  mid_data;
   logic      back_ready;
   color_type color;

   assign pixel.hue        = req_chan.hue;
   assign pixel.saturation = req_chan.saturation;
   assign pixel.brightness = req_chan.brightness;
   assign req_chan.ready   = !reset && front_ready;

   hsvrgb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (front_ready),
      .in_pixel  (pixel),
      .out_valid (front_valid),
      .out_ready (mid_ready),
      .out_data  (front_data)
   );

   hsvrgb_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (mid_ready),
      .in_data   (front_data),
      .out_valid (mid_valid),
      .out_ready (back_ready),
      .out_data  (mid_data)
   );

   hsvrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (back_ready),
      .in_data   (mid_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_color (color)
   );

   assign rsp_chan.red_level    = color.red_level;
   assign rsp_chan.green_level  = color.green_level;
   assign rsp_chan.blue_level   = color.blue_level;
   assign rsp_chan.packed_color = color.packed_color;

endmodule

// ===== hdl/hsvrgb_checker.sv =====
// Port-level checks for the HSV to RGB332 converter, bound to the top level.
`timescale 1ns / 1ps

module hsvrgb_checker
   import hsvrgb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_hue,
   input logic [8:0]  req_saturation,
   input logic [8:0]  req_brightness,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_red_level,
   input logic [2:0]  rsp_green_level,
   input logic [1:0]  rsp_blue_level,
   input logic [7:0]  rsp_packed_color
);

   logic drain;
   logic take_black;
   logic take_white;

   // pipeline moves freely while the sink takes every beat
   assign drain      = rsp_ready && !reset;
   assign take_black = req_valid && req_ready &&
                       (req_brightness == 9'd0 ||
                        (req_hue >= HueLimit && req_saturation >= FracOne));
   assign take_white = req_valid && req_ready &&
                       req_saturation == 9'd0 && req_brightness >= FracOne;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown after reset");

   a_packed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packed_color == {rsp_red_level, rsp_green_level, rsp_blue_level})
      else $error("packed colour disagrees with channel levels");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_color))
      else $error("stalled result beat changed");

   a_black_latency: assert property (@(posedge clock) disable iff (reset)
      $past(take_black, 5) && $past(drain, 1) && $past(drain, 2) &&
      $past(drain, 3) && $past(drain, 4) |-> rsp_valid && rsp_packed_color == 8'd0)
      else $error("black pixel not delivered as black after five cycles");

   a_white_latency: assert property (@(posedge clock) disable iff (reset)
      $past(take_white, 5) && $past(drain, 1) && $past(drain, 2) &&
      $past(drain, 3) && $past(drain, 4) |-> rsp_valid && rsp_packed_color == 8'hFF)
      else $error("white pixel not delivered as white after five cycles");

endmodule

bind hsv_to_rgb332_unit hsvrgb_checker u_hsvrgb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_hue          (req_chan.hue),
   .req_saturation   (req_chan.saturation),
   .req_brightness   (req_chan.brightness),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_red_level    (rsp_chan.red_level),
   .rsp_green_level  (rsp_chan.green_level),
   .rsp_blue_level   (rsp_chan.blue_level),
   .rsp_packed_color (rsp_chan.packed_color)
);

// ===== test/hsv_to_rgb332_unit_test.sv =====
// Self-checking testbench for the HSV to RGB332 converter: random and corner pixels.
`timescale 1ns / 1ps

module hsv_to_rgb332_unit_test;
   import hsvrgb_pkg::*;

   localparam int unsigned RandomPixels = 1000;
   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned DrainCycles  = 12;
   // 65536 * 3840: every channel numerator is a fraction over this
   localparam longint unsigned LevelDenom = 64'd251658240;

   logic clock = 1'b0;
   logic reset;

   hsvrgb_req_if req_chan ();
   hsvrgb_rsp_if rsp_chan ();

   hsv_to_rgb332_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pixel_type   pixels_to_send[$];
   color_type   colors_due[$];
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   logic        req_taken;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact fixed-point conversion of one pixel to its 3-3-2 colour.
   function automatic color_type convert_pixel(input pixel_type px);
      color_type       c;
      longint unsigned sat, bri, chroma, offset, pos, ramp, second;
      longint unsigned red_num, green_num, blue_num;
      int unsigned     sector_idx;
      sat = (px.saturation > 9'd256) ? 64'd256 : 64'(px.saturation);
      bri = (px.brightness > 9'd256) ? 64'd256 : 64'(px.brightness);
      chroma = bri * sat * 64'd3840;
      offset = bri * 64'd256 * 64'd3840 - chroma;
      red_num = 0;
      green_num = 0;
      blue_num = 0;
      if (px.hue < 16'd23040) begin
         sector_idx = 32'(px.hue / 16'd3840);
         pos = 64'(px.hue % 16'd3840);
         ramp = sector_idx[0] ? (64'd3840 - pos) : pos;
         second = bri * sat * ramp;
         case (sector_type'(sector_idx))
            SECTOR_RED_YELLOW: begin
               red_num = chroma;  green_num = second;
            end
            SECTOR_YELLOW_GREEN: begin
               red_num = second;  green_num = chroma;
            end
            SECTOR_GREEN_CYAN: begin
               green_num = chroma; blue_num = second;
            end
            SECTOR_CYAN_BLUE: begin
               green_num = second; blue_num = chroma;
            end
            SECTOR_BLUE_MAGENTA: begin
               red_num = second;  blue_num = chroma;
            end
            default: begin
               red_num = chroma;  blue_num = second;
            end
         endcase
      end
      c.red_level    = 3'(((red_num + offset) * 64'd7) / LevelDenom);
      c.green_level  = 3'(((green_num + offset) * 64'd7) / LevelDenom);
      c.blue_level   = 2'(((blue_num + offset) * 64'd3) / LevelDenom);
      c.packed_color = {c.red_level, c.green_level, c.blue_level};
      return c;
   endfunction

   function automatic logic [8:0] random_fraction();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10)      return ($urandom_range(1) != 0) ? 9'd256 : 9'd0;
      else if (pick < 30) return 9'($urandom_range(511));
      else                return 9'($urandom_range(256));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type   px;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8)       px.hue = 16'($urandom_range(6) * 3840);
      else if (pick < 28) px.hue = 16'($urandom_range(65535));
      else                px.hue = 16'($urandom_range(23039));
      px.saturation = random_fraction();
      px.brightness = random_fraction();
      return px;
   endfunction

   // Driver: present the next pixel once the current beat is taken.
   always @(posedge clock) req_taken <= req_chan.valid & req_chan.ready;

   always @(negedge clock) begin
      pixel_type px;
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.hue        <= '0;
         req_chan.saturation <= '0;
         req_chan.brightness <= '0;
      end else if (!req_chan.valid || req_taken) begin
         if (pixels_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            px = pixels_to_send.pop_front();
            req_chan.hue        <= px.hue;
            req_chan.saturation <= px.saturation;
            req_chan.brightness <= px.brightness;
            req_chan.valid      <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitor: check result beats against the oldest due colour, then log new pixels.
   always @(posedge clock) begin
      color_type want;
      pixel_type px;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (colors_due.size() == 0) begin
               $error("unexpected result beat: packed_color %0h", rsp_chan.packed_color);
               mismatch_count++;
            end else begin
               want = colors_due.pop_front();
               if (rsp_chan.red_level !== want.red_level) begin
                  $error("red_level: expected %0d, got %0d", want.red_level,
                         rsp_chan.red_level);
                  mismatch_count++;
               end
               if (rsp_chan.green_level !== want.green_level) begin
                  $error("green_level: expected %0d, got %0d", want.green_level,
                         rsp_chan.green_level);
                  mismatch_count++;
               end
               if (rsp_chan.blue_level !== want.blue_level) begin
                  $error("blue_level: expected %0d, got %0d", want.blue_level,
                         rsp_chan.blue_level);
                  mismatch_count++;
               end
               if (rsp_chan.packed_color !== want.packed_color) begin
                  $error("packed_color: expected %0h, got %0h", want.packed_color,
                         rsp_chan.packed_color);
                  mismatch_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            px.hue        = req_chan.hue;
            px.saturation = req_chan.saturation;
            px.brightness = req_chan.brightness;
            colors_due.push_back(convert_pixel(px));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("hsv_to_rgb332_unit verification failed");
         $finish;
      end
   end

   initial begin
      pixel_type   px;
      int unsigned phase_send[4];
      int unsigned phase_stall[4];
      phase_send  = '{0, 67, 0, 7};
      phase_stall = '{0, 0, 67, 7};
      reset = 1'b1;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;

      // Corners: sector edges, last hue before wrap, hues past 360, fractions above 1.0.
      pixels_to_send.push_back('{16'd0,     9'd256, 9'd256});
      pixels_to_send.push_back('{16'd1920,  9'd256, 9'd256});
      pixels_to_send.push_back('{16'd3839,  9'd256, 9'd256});
      pixels_to_send.push_back('{16'd3840,  9'd256, 9'd256});
      pixels_to_send.push_back('{16'd7680,  9'd256, 9'd256});
      pixels_to_send.push_back('{16'd11520, 9'd256, 9'd256});
      pixels_to_send.push_back('{16'd15360, 9'd256, 9'd256});
      pixels_to_send.push_back('{16'd19200, 9'd256, 9'd256});
      pixels_to_send.push_back('{16'd23039, 9'd256, 9'd256});
      pixels_to_send.push_back('{16'd23040, 9'd256, 9'd256});
      pixels_to_send.push_back('{16'd23040, 9'd128, 9'd256});
      pixels_to_send.push_back('{16'd65535, 9'd0,   9'd256});
      pixels_to_send.push_back('{16'd65535, 9'd511, 9'd511});
      pixels_to_send.push_back('{16'd5000,  9'd0,   9'd0});
      pixels_to_send.push_back('{16'd5000,  9'd0,   9'd256});
      pixels_to_send.push_back('{16'd5000,  9'd257, 9'd200});
      pixels_to_send.push_back('{16'd5000,  9'd511, 9'd511});
      pixels_to_send.push_back('{16'd13000, 9'd200, 9'd257});
      pixels_to_send.push_back('{16'd17000, 9'd255, 9'd255});
      pixels_to_send.push_back('{16'd21000, 9'd1,   9'd1});
      pixels_to_send.push_back('{16'd9000,  9'd100, 9'd511});
      pixels_to_send.push_back('{16'd32768, 9'd170, 9'd85});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase_send[phase];
         rsp_stall_pct = phase_stall[phase];
         for (int n = 0; n < RandomPixels / 4; n++) begin
            px = random_pixel();
            pixels_to_send.push_back(px);
         end
         while (pixels_to_send.size() > 0 || req_chan.valid) @(posedge clock);
      end

      while (colors_due.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("hsv_to_rgb332_unit verification clean");
      end else begin
         $display("hsv_to_rgb332_unit verification failed");
      end
      $finish;
   end

endmodule
